// ----- rtl/cihb_pkg.sv -----
// ----------------------------------------------------------------------------
// cihb_pkg
// Shared types and constants for the coupled Ising heat-bath step block:
// item structs, field widths, register indexes and register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package cihb_pkg;

  // Field widths fixed by the item format
  localparam int SITE_W     = 6;
  localparam int WORD_W     = 32;
  localparam int THR_W      = 33;
  localparam int GRID_W     = 7;
  localparam int DIFF_OUT_W = 13;
  localparam int STEP_W     = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_THR    = 5;

  localparam int DEFAULT_MAX_SIDE = 64;

  // Register reset values
  localparam logic [GRID_W-1:0] RESET_GRID_SIZE = 7'd64;
  localparam logic [THR_W-1:0]  RESET_THR_M4    = 33'd1430626;
  localparam logic [THR_W-1:0]  RESET_THR_M2    = 33'd511245864;
  localparam logic [THR_W-1:0]  RESET_THR_ZERO  = 33'd2147483648;
  localparam logic [THR_W-1:0]  RESET_THR_P2    = 33'd3783721431;
  localparam logic [THR_W-1:0]  RESET_THR_P4    = 33'd4293536669;

  // Reported difference count saturates here
  localparam logic [DIFF_OUT_W-1:0] DIFF_SAT = '1;
  localparam logic [STEP_W-1:0]     STEP_MAX = '1;

  // Request kinds
  localparam logic REQ_UPDATE  = 1'b0;
  localparam logic REQ_RESTART = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_SIZE = 3'd0,
    CFG_THR_M4    = 3'd1,
    CFG_THR_M2    = 3'd2,
    CFG_THR_ZERO  = 3'd3,
    CFG_THR_P2    = 3'd4,
    CFG_THR_P4    = 3'd5
  } cfg_reg_t;

  // Input item
  typedef struct packed {
    logic              req_type;
    logic [SITE_W-1:0] site_row;
    logic [SITE_W-1:0] site_col;
    logic [WORD_W-1:0] rand_word;
  } in_t;

  // Result item
  typedef struct packed {
    logic                  upper_spin;
    logic                  lower_spin;
    logic [DIFF_OUT_W-1:0] diff_count;
    logic                  coupled;
    logic [STEP_W-1:0]     step_count;
    logic                  bad_site;
  } out_t;

endpackage

`default_nettype wire

// ----- rtl/cihb_lattice_ram.sv -----
// ----------------------------------------------------------------------------
// cihb_lattice_ram
// Spin memory for both lattices: bit 1 holds the upper lattice spin, bit 0
// the lower lattice spin. One write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module cihb_lattice_ram #(
  parameter int ADDR_W = 12
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [1:0]        wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [1:0]        rd_data
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered read
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- rtl/coupled_ising_heat_bath_step.sv -----
// A site update steps through S_READ (down, up, right, left, center taps)
// and S_DECIDE, then delivers its result; restart and out-of-grid items
// deliver theirs in the cycle after start is taken. Items do not overlap:
// the single read port of the spin memory reads the four neighbors and the
// site in turn. Reset and restart fill all 4^ceil(log2(MAX_SIDE)) memory
// words (4096 at MAX_SIDE = 64) with busy high; results cannot be stalled.
// ----------------------------------------------------------------------------
// coupled_ising_heat_bath_step
// Two heat-bath Ising lattices on a torus driven by a shared random word,
// with a count of sites where the lattices differ and an update counter.
// ----------------------------------------------------------------------------
`default_nettype none

module coupled_ising_heat_bath_step #(
  parameter int MAX_SIDE = cihb_pkg::DEFAULT_MAX_SIDE
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // Item command channel
  input  wire logic                         start,
  output logic                              busy,
  input  wire cihb_pkg::in_t                req,
  output logic                              done,
  output cihb_pkg::out_t                    res,
  // Configuration write channel
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [cihb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [cihb_pkg::THR_W-1:0]   cfg_data
);

  import cihb_pkg::*;

  localparam int CW         = $clog2(MAX_SIDE);
  localparam int ADDR_W     = 2 * CW;
  localparam int SIDE_W     = $clog2(MAX_SIDE + 1);
  localparam int CELLS      = MAX_SIDE * MAX_SIDE;
  localparam int DIFF_W     = $clog2(CELLS + 1);
  localparam int RESET_SIDE = (MAX_SIDE < 64) ? MAX_SIDE : 64;
  localparam int RESET_DIFF = RESET_SIDE * RESET_SIDE;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FILL,
    S_READ,
    S_DECIDE
  } state_t;

  // Order in which the site's taps are read
  typedef enum logic [2:0] {
    TAP_DOWN,
    TAP_UP,
    TAP_RIGHT,
    TAP_LEFT,
    TAP_CENTER
  } tap_t;

  state_t state;
  tap_t   tap;

  // Configuration registers
  logic [GRID_W-1:0] grid_size;
  logic [THR_W-1:0]  thresh [NUM_THR];

  // Counters
  logic [DIFF_W-1:0] differ_total;
  logic [STEP_W-1:0] update_total;

  // Item registers
  logic [CW-1:0]     row_q;
  logic [CW-1:0]     col_q;
  logic [WORD_W-1:0] word_q;
  logic [2:0]        ku;
  logic [2:0]        kl;
  logic [ADDR_W-1:0] fill_addr;

  // Memory ports
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [1:0]        wr_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [1:0]        rd_data;

  // Combinational helpers
  logic [SIDE_W-1:0]        side;
  logic [2*SIDE_W-1:0]      side_sq;
  logic [CW+SITE_W-1:0]     row_wide;
  logic [CW+SITE_W-1:0]     col_wide;
  logic                     site_bad;
  logic [CW-1:0]            row_p;
  logic [CW-1:0]            row_m;
  logic [CW-1:0]            col_p;
  logic [CW-1:0]            col_m;
  logic [THR_W-1:0]         thr_u;
  logic [THR_W-1:0]         thr_l;
  logic                     new_u;
  logic                     new_l;
  logic                     was_diff;
  logic                     now_diff;
  logic [DIFF_W-1:0]        differ_next;
  logic [STEP_W-1:0]        update_next;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);

  function automatic logic [DIFF_OUT_W-1:0] sat_diff(input logic [DIFF_W-1:0] d);
    if (32'(d) > 32'(DIFF_SAT)) begin
      return DIFF_SAT;
    end
    return DIFF_OUT_W'(d);
  endfunction

  function automatic logic [THR_W-1:0] pick_thr(input logic [2:0] k,
                                                input logic [THR_W-1:0] t0,
                                                input logic [THR_W-1:0] t1,
                                                input logic [THR_W-1:0] t2,
                                                input logic [THR_W-1:0] t3,
                                                input logic [THR_W-1:0] t4);
    logic [THR_W-1:0] t;
    unique case (k)
      3'd0:    t = t0;
      3'd1:    t = t1;
      3'd2:    t = t2;
      3'd3:    t = t3;
      default: t = t4;
    endcase
    return t;
  endfunction

  // Effective side, clamped to 1..MAX_SIDE
  always_comb begin
    if (grid_size == '0) begin
      side = SIDE_W'(1);
    end else if (32'(grid_size) > 32'(MAX_SIDE)) begin
      side = SIDE_W'(MAX_SIDE);
    end else begin
      side = SIDE_W'(grid_size);
    end
  end

  assign side_sq  = (2*SIDE_W)'(side) * (2*SIDE_W)'(side);
  assign row_wide = (CW+SITE_W)'(req.site_row);
  assign col_wide = (CW+SITE_W)'(req.site_col);
  assign site_bad = (32'(req.site_row) >= 32'(side)) || (32'(req.site_col) >= 32'(side));

  // Wrapped neighbor coordinates
  always_comb begin
    row_p = (32'(row_q) + 32'd1 == 32'(side)) ? '0 : CW'(32'(row_q) + 32'd1);
    row_m = (row_q == '0) ? CW'(32'(side) - 32'd1) : CW'(32'(row_q) - 32'd1);
    col_p = (32'(col_q) + 32'd1 == 32'(side)) ? '0 : CW'(32'(col_q) + 32'd1);
    col_m = (col_q == '0) ? CW'(32'(side) - 32'd1) : CW'(32'(col_q) - 32'd1);
  end

  // Read address per tap
  always_comb begin
    unique case (tap)
      TAP_DOWN:   rd_addr = {row_p, col_q};
      TAP_UP:     rd_addr = {row_m, col_q};
      TAP_RIGHT:  rd_addr = {row_q, col_p};
      TAP_LEFT:   rd_addr = {row_q, col_m};
      TAP_CENTER: rd_addr = {row_q, col_q};
      default:    rd_addr = {row_q, col_q};
    endcase
  end

  // Heat-bath decision; the center spin is on rd_data in S_DECIDE
  always_comb begin
    thr_u    = pick_thr(ku, thresh[0], thresh[1], thresh[2], thresh[3], thresh[4]);
    thr_l    = pick_thr(kl, thresh[0], thresh[1], thresh[2], thresh[3], thresh[4]);
    new_u    = ({1'b0, word_q} <= thr_u);
    new_l    = ({1'b0, word_q} <= thr_l);
    was_diff = rd_data[1] ^ rd_data[0];
    now_diff = new_u ^ new_l;
    differ_next = differ_total;
    if (!was_diff && now_diff) begin
      if (32'(differ_total) < 32'(CELLS)) begin
        differ_next = differ_total + DIFF_W'(1);
      end
    end else if (was_diff && !now_diff) begin
      if (differ_total != '0) begin
        differ_next = differ_total - DIFF_W'(1);
      end
    end
    update_next = (update_total == STEP_MAX) ? update_total : update_total + STEP_W'(1);
  end

  // Memory write port: fill pass or write-back of the updated site
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {row_q, col_q};
    wr_data = {new_u, new_l};
    if (state == S_FILL) begin
      wr_en   = 1'b1;
      wr_addr = fill_addr;
      wr_data = 2'b10;
    end else if (state == S_DECIDE) begin
      wr_en = 1'b1;
    end
  end

  cihb_lattice_ram #(
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size <= RESET_GRID_SIZE;
      thresh[0] <= RESET_THR_M4;
      thresh[1] <= RESET_THR_M2;
      thresh[2] <= RESET_THR_ZERO;
      thresh[3] <= RESET_THR_P2;
      thresh[4] <= RESET_THR_P4;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_GRID_SIZE: grid_size <= cfg_data[GRID_W-1:0];
        CFG_THR_M4:    thresh[0] <= cfg_data;
        CFG_THR_M2:    thresh[1] <= cfg_data;
        CFG_THR_ZERO:  thresh[2] <= cfg_data;
        CFG_THR_P2:    thresh[3] <= cfg_data;
        CFG_THR_P4:    thresh[4] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer with counters and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_FILL;
      tap          <= TAP_DOWN;
      fill_addr    <= '0;
      differ_total <= DIFF_W'(RESET_DIFF);
      update_total <= '0;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (req.req_type == REQ_RESTART) begin
              // Refill both lattices and restart the counters
              differ_total   <= DIFF_W'(side_sq);
              update_total   <= '0;
              fill_addr      <= '0;
              state          <= S_FILL;
              done           <= 1'b1;
              res.upper_spin <= 1'b0;
              res.lower_spin <= 1'b0;
              res.diff_count <= sat_diff(DIFF_W'(side_sq));
              res.coupled    <= (side_sq == '0);
              res.step_count <= '0;
              res.bad_site   <= 1'b0;
            end else if (site_bad) begin
              // Out of grid: report counts, change nothing
              done           <= 1'b1;
              res.upper_spin <= 1'b0;
              res.lower_spin <= 1'b0;
              res.diff_count <= sat_diff(differ_total);
              res.coupled    <= (differ_total == '0);
              res.step_count <= update_total;
              res.bad_site   <= 1'b1;
            end else begin
              row_q  <= row_wide[CW-1:0];
              col_q  <= col_wide[CW-1:0];
              word_q <= req.rand_word;
              ku     <= '0;
              kl     <= '0;
              tap    <= TAP_DOWN;
              state  <= S_READ;
            end
          end
        end
        S_FILL: begin
          fill_addr <= fill_addr + ADDR_W'(1);
          if (fill_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_READ: begin
          // Data from the previous tap arrives now
          if (tap != TAP_DOWN) begin
            ku <= ku + 3'(rd_data[1]);
            kl <= kl + 3'(rd_data[0]);
          end
          unique case (tap)
            TAP_DOWN:   tap <= TAP_UP;
            TAP_UP:     tap <= TAP_RIGHT;
            TAP_RIGHT:  tap <= TAP_LEFT;
            TAP_LEFT:   tap <= TAP_CENTER;
            TAP_CENTER: begin
              tap   <= TAP_DOWN;
              state <= S_DECIDE;
            end
            default:    tap <= TAP_DOWN;
          endcase
        end
        S_DECIDE: begin
          differ_total   <= differ_next;
          update_total   <= update_next;
          done           <= 1'b1;
          res.upper_spin <= new_u;
          res.lower_spin <= new_l;
          res.diff_count <= sat_diff(differ_next);
          res.coupled    <= (differ_next == '0);
          res.step_count <= update_next;
          res.bad_site   <= 1'b0;
          state          <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
